@@ hw/rtl/sntt_pkg.sv @@
// Shared types and constants for the sorted top-N name table.
// Holds the operation, status and state codes, the table entry layout and the
// command and status bundles between controller and datapath. No dependencies.
package sntt_pkg;

  localparam int NAME_W    = 64;
  localparam int SCORE_W   = 31;
  localparam int INDEX_W   = 3;
  localparam int ROW_W     = 3;
  localparam int COUNT_W   = 4;
  localparam int S_TDATA_W = 104;
  localparam int M_TDATA_W = 168;

  // printable range and the case-folding letters
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_TILDE   = 8'd126;
  localparam logic [7:0] CH_QUERY   = 8'h3F;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_BEST   = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REJECT  = 2'd1,
    ST_NO_NAME = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    RES_HOLD,
    RES_REJECT,
    RES_MISS,
    RES_RANGE,
    RES_PLACED,
    RES_ENTRY
  } res_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_FULL,
    S_INS_WALK,
    S_INS_PLACE,
    S_LOOK,
    S_READ,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [NAME_W-1:0]  name;
    logic [SCORE_W-1:0] score;
  } entry_t;

  typedef struct packed {
    logic     load_in;
    logic     idx_last;
    logic     idx_zero;
    logic     idx_entry;
    logic     idx_dec;
    logic     idx_inc;
    logic     rd_at;
    logic     rd_below;
    logic     wr_shift;
    logic     wr_new;
    res_sel_t res;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic pre_ok;
    logic full;
    logic empty;
    logic rd_lower;
    logic idx_zero;
    logic idx_one;
    logic idx_last;
    logic match;
    logic index_ok;
    logic out_free;
  } sts_t;

endpackage

@@ hw/rtl/sorted_top_n_name_table_unit.sv @@
// Top level of the sorted top-N name table: stream ports, field packing and
// the controller and datapath instances. Depends on sntt_pkg, sntt_ctrl, sntt_dp.
//
//   group  direction  tdata fields (low bit up)                    tuser
//   s_*    in         name_bytes, score_in, entry_index, zero pad  op
//   m_*    out        row, score_out, name_out, entry_count,       status
//                     last_name, zero pad
//
// One operation at a time; s_tready is high only when idle. A placed insert
// walks up from the bottom, moving each lower-scoring row down, then writes the
// entry; a full table checks the bottom row first, and a rejected insert writes
// nothing. Lookup compares rows from the top down; row read fetches one row. The
// entry RAM's single read port sets the per-row step. Reset clears the count,
// last name, output valid and state; rows are written before they are read. A
// stalled beat holds the block in S_FINISH, and s_tready low, until it is loaded.
module sorted_top_n_name_table_unit #(
  parameter int TABLE_ENTRIES = 8,
  parameter int NAME_CHARS    = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // name_bytes[63:0], score_in[94:64], entry_index[97:95], zero pad
  input  logic [sntt_pkg::S_TDATA_W-1:0]    s_tdata,
  // op[1:0]
  input  logic [1:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // row[2:0], score_out[33:3], name_out[97:34], entry_count[101:98],
  // last_name[165:102], zero pad
  output logic [sntt_pkg::M_TDATA_W-1:0]    m_tdata,
  // status[1:0]
  output logic [1:0]                        m_tuser
);

  sntt_pkg::cmd_t                      cmd;
  sntt_pkg::sts_t                      sts;
  sntt_pkg::status_t                   out_status;
  logic [sntt_pkg::ROW_W-1:0]          out_row;
  logic [sntt_pkg::SCORE_W-1:0]        out_score;
  logic [sntt_pkg::NAME_W-1:0]         out_name;
  logic [sntt_pkg::COUNT_W-1:0]        out_count;
  logic [sntt_pkg::NAME_W-1:0]         out_last;

  sntt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  sntt_dp #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .NAME_CHARS   (NAME_CHARS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_op     (s_tuser),
    .in_name   (s_tdata[63:0]),
    .in_score  (s_tdata[94:64]),
    .in_index  (s_tdata[97:95]),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .out_status(out_status),
    .out_row   (out_row),
    .out_score (out_score),
    .out_name  (out_name),
    .out_count (out_count),
    .out_last  (out_last)
  );

  assign m_tdata = {2'b00, out_last, out_count, out_name, out_score, out_row};
  assign m_tuser = out_status;

endmodule

@@ hw/rtl/sntt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sntt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/sntt_ctrl.sv @@
// Controller for the sorted top-N name table: sequences insert, lookup and
// row read over the datapath. Depends on sntt_pkg.
module sntt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  sntt_pkg::sts_t sts,
  output sntt_pkg::cmd_t cmd
);

  sntt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sntt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.res    = sntt_pkg::RES_HOLD;
    s_tready   = 1'b0;
    unique case (state)
      sntt_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = sntt_pkg::S_DISPATCH;
        end
      end
      sntt_pkg::S_DISPATCH: begin
        unique case (sts.op)
          sntt_pkg::OP_INSERT: begin
            if (!sts.pre_ok) begin
              cmd.res    = sntt_pkg::RES_REJECT;
              state_next = sntt_pkg::S_FINISH;
            end else if (sts.full) begin
              // check the bottom row before anything moves
              cmd.idx_last = 1'b1;
              cmd.rd_at    = 1'b1;
              state_next   = sntt_pkg::S_INS_FULL;
            end else if (sts.empty) begin
              cmd.idx_last = 1'b1;
              state_next   = sntt_pkg::S_INS_PLACE;
            end else begin
              cmd.idx_last = 1'b1;
              cmd.rd_below = 1'b1;
              state_next   = sntt_pkg::S_INS_WALK;
            end
          end
          sntt_pkg::OP_BEST: begin
            if (sts.empty) begin
              cmd.res    = sntt_pkg::RES_MISS;
              state_next = sntt_pkg::S_FINISH;
            end else begin
              cmd.idx_zero = 1'b1;
              cmd.rd_at    = 1'b1;
              state_next   = sntt_pkg::S_LOOK;
            end
          end
          sntt_pkg::OP_READ: begin
            if (sts.index_ok) begin
              cmd.idx_entry = 1'b1;
              cmd.rd_at     = 1'b1;
              state_next    = sntt_pkg::S_READ;
            end else begin
              cmd.res    = sntt_pkg::RES_RANGE;
              state_next = sntt_pkg::S_FINISH;
            end
          end
          default: begin
            cmd.res    = sntt_pkg::RES_RANGE;
            state_next = sntt_pkg::S_FINISH;
          end
        endcase
      end
      sntt_pkg::S_INS_FULL: begin
        if (!sts.rd_lower) begin
          cmd.res    = sntt_pkg::RES_REJECT;
          state_next = sntt_pkg::S_FINISH;
        end else if (sts.idx_zero) begin
          state_next = sntt_pkg::S_INS_PLACE;
        end else begin
          cmd.rd_below = 1'b1;
          state_next   = sntt_pkg::S_INS_WALK;
        end
      end
      sntt_pkg::S_INS_WALK: begin
        // move the lower-scoring row down one and fetch the row above it
        if (sts.rd_lower) begin
          cmd.wr_shift = 1'b1;
          cmd.idx_dec  = 1'b1;
          if (sts.idx_one) begin
            state_next = sntt_pkg::S_INS_PLACE;
          end else begin
            cmd.rd_below = 1'b1;
          end
        end else begin
          state_next = sntt_pkg::S_INS_PLACE;
        end
      end
      sntt_pkg::S_INS_PLACE: begin
        cmd.wr_new = 1'b1;
        cmd.res    = sntt_pkg::RES_PLACED;
        state_next = sntt_pkg::S_FINISH;
      end
      sntt_pkg::S_LOOK: begin
        if (sts.match) begin
          cmd.res    = sntt_pkg::RES_ENTRY;
          state_next = sntt_pkg::S_FINISH;
        end else if (sts.idx_last) begin
          cmd.res    = sntt_pkg::RES_MISS;
          state_next = sntt_pkg::S_FINISH;
        end else begin
          cmd.idx_inc = 1'b1;
          cmd.rd_at   = 1'b1;
        end
      end
      sntt_pkg::S_READ: begin
        cmd.res    = sntt_pkg::RES_ENTRY;
        state_next = sntt_pkg::S_FINISH;
      end
      sntt_pkg::S_FINISH: begin
        // hold until the output register is free
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = sntt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sntt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/sntt_dp.sv @@
// Datapath for the sorted top-N name table: input capture, name sanitising and
// matching, row pointer, entry RAM, result and output registers.
// Depends on sntt_pkg and sntt_ram.
module sntt_dp #(
  parameter int TABLE_ENTRIES = 8,
  parameter int NAME_CHARS    = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  sntt_pkg::cmd_t                  cmd,
  output sntt_pkg::sts_t                  sts,
  input  logic [1:0]                      in_op,
  input  logic [sntt_pkg::NAME_W-1:0]     in_name,
  input  logic [sntt_pkg::SCORE_W-1:0]    in_score,
  input  logic [sntt_pkg::INDEX_W-1:0]    in_index,
  input  logic                            m_tready,
  output logic                            m_tvalid,
  output sntt_pkg::status_t               out_status,
  output logic [sntt_pkg::ROW_W-1:0]      out_row,
  output logic [sntt_pkg::SCORE_W-1:0]    out_score,
  output logic [sntt_pkg::NAME_W-1:0]     out_name,
  output logic [sntt_pkg::COUNT_W-1:0]    out_count,
  output logic [sntt_pkg::NAME_W-1:0]     out_last
);

  localparam int AW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW   = $clog2(TABLE_ENTRIES + 1);
  localparam int CMPW = (CW > sntt_pkg::INDEX_W) ? CW : sntt_pkg::INDEX_W;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= sntt_pkg::CH_LOWER_A && c <= sntt_pkg::CH_LOWER_Z) begin
      r = c - sntt_pkg::CH_LOWER_A + sntt_pkg::CH_UPPER_A;
    end
    return r;
  endfunction

  function automatic logic [sntt_pkg::NAME_W-1:0] sanitise(
    input logic [sntt_pkg::NAME_W-1:0] raw
  );
    logic [sntt_pkg::NAME_W-1:0] res;
    logic                        alive;
    logic [7:0]                  c;
    res   = '0;
    alive = 1'b1;
    for (int n = 0; n < 8; n++) begin
      c = raw[8*n +: 8];
      if (n < NAME_CHARS && alive) begin
        if (c == 8'd0) begin
          alive = 1'b0;
        end else begin
          if (c < sntt_pkg::CH_SPACE || c > sntt_pkg::CH_TILDE) begin
            c = sntt_pkg::CH_QUERY;
          end
          res[8*n +: 8] = c;
        end
      end
    end
    return res;
  endfunction

  // compare up to and including the stored terminator, one byte past the name
  function automatic logic name_match(
    input logic [sntt_pkg::NAME_W-1:0] stored,
    input logic [sntt_pkg::NAME_W-1:0] probe
  );
    logic       live;
    logic       m;
    logic [7:0] a;
    logic [7:0] b;
    live = 1'b1;
    m    = 1'b1;
    for (int k = 0; k <= 8; k++) begin
      a = (k < 8) ? stored[8*(k%8) +: 8] : 8'd0;
      b = (k < 8) ? probe[8*(k%8) +: 8] : 8'd0;
      if (k <= NAME_CHARS && live) begin
        if (upcase(a) != upcase(b)) begin
          m    = 1'b0;
          live = 1'b0;
        end else if (a == 8'd0) begin
          live = 1'b0;
        end
      end
    end
    return m;
  endfunction

  sntt_pkg::op_t                 op;
  logic [sntt_pkg::NAME_W-1:0]   probe;
  logic [sntt_pkg::NAME_W-1:0]   clean;
  logic [sntt_pkg::SCORE_W-1:0]  score;
  logic [sntt_pkg::INDEX_W-1:0]  index;
  logic [AW-1:0]                 idx, idx_next;
  logic [CW-1:0]                 count;
  logic [sntt_pkg::NAME_W-1:0]   recent;
  logic                          full;

  sntt_pkg::status_t             res_status;
  logic [sntt_pkg::ROW_W-1:0]    res_row;
  logic [sntt_pkg::SCORE_W-1:0]  res_score;
  logic [sntt_pkg::NAME_W-1:0]   res_name;

  sntt_pkg::entry_t              rd_data, wr_data;
  logic [AW-1:0]                 rd_addr;
  logic                          rd_en, wr_en;

  assign full = (count == CW'(TABLE_ENTRIES));

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op    <= sntt_pkg::op_t'(in_op);
      probe <= in_name;
      clean <= sanitise(in_name);
      score <= in_score;
      index <= in_index;
    end
  end

  always_comb begin
    idx_next = idx;
    if (cmd.idx_last) begin
      idx_next = full ? AW'(TABLE_ENTRIES - 1) : AW'(count);
    end else if (cmd.idx_zero) begin
      idx_next = '0;
    end else if (cmd.idx_entry) begin
      idx_next = AW'(index);
    end else if (cmd.idx_dec) begin
      idx_next = idx - AW'(1);
    end else if (cmd.idx_inc) begin
      idx_next = idx + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
  end

  assign rd_en   = cmd.rd_at | cmd.rd_below;
  assign rd_addr = cmd.rd_below ? idx_next - AW'(1) : idx_next;
  assign wr_en   = cmd.wr_shift | cmd.wr_new;
  always_comb begin
    wr_data = rd_data;
    if (cmd.wr_new) begin
      wr_data.name  = clean;
      wr_data.score = score;
    end
  end

  sntt_ram #(
    .WIDTH($bits(sntt_pkg::entry_t)),
    .DEPTH(TABLE_ENTRIES)
  ) u_entries (
    .clk  (clk),
    .we   (wr_en),
    .waddr(idx),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      recent <= '0;
    end else if (cmd.wr_new) begin
      if (!full) begin
        count <= count + CW'(1);
      end
      recent <= clean;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.res) inside
      sntt_pkg::RES_REJECT, sntt_pkg::RES_MISS, sntt_pkg::RES_RANGE: begin
        res_status <= (cmd.res == sntt_pkg::RES_REJECT) ? sntt_pkg::ST_REJECT :
                      (cmd.res == sntt_pkg::RES_MISS)   ? sntt_pkg::ST_NO_NAME :
                                                          sntt_pkg::ST_RANGE;
        res_row    <= '0;
        res_score  <= '0;
        res_name   <= '0;
      end
      sntt_pkg::RES_PLACED: begin
        res_status <= sntt_pkg::ST_OK;
        res_row    <= sntt_pkg::ROW_W'(idx);
        res_score  <= score;
        res_name   <= clean;
      end
      sntt_pkg::RES_ENTRY: begin
        res_status <= sntt_pkg::ST_OK;
        res_row    <= sntt_pkg::ROW_W'(idx);
        res_score  <= rd_data.score;
        res_name   <= rd_data.name;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status <= res_status;
      out_row    <= res_row;
      out_score  <= res_score;
      out_name   <= res_name;
      out_count  <= sntt_pkg::COUNT_W'(count);
      out_last   <= recent;
    end
  end

  always_comb begin
    sts          = '0;
    sts.op       = op;
    sts.pre_ok   = (score != '0) && (clean != '0);
    sts.full     = full;
    sts.empty    = (count == '0);
    sts.rd_lower = (rd_data.score < score);
    sts.idx_zero = (idx == '0);
    sts.idx_one  = (idx == AW'(1));
    sts.idx_last = ((CW'(idx) + CW'(1)) == count);
    sts.match    = name_match(rd_data.name, probe);
    sts.index_ok = (CMPW'(index) < CMPW'(count));
    sts.out_free = !m_tvalid || m_tready;
  end

endmodule
